### rtl/sysl_pkg.sv
// shared types, constants and the header byte function for the sysex page loader
// no dependencies
`default_nettype none

package sysl_pkg;

   localparam int PAGE_BYTES_DEF = 128;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;
   localparam logic [7:0] STATUS_BIT  = 8'h80;
   localparam logic [6:0] CMD_RESET   = 7'h7F;
   localparam logic [6:0] CMD_PAGE    = 7'h7E;
   localparam logic [6:0] CMD_SUB     = 7'h00;
   localparam int         HDR_LEN     = 6;

   localparam logic [1:0] EV_WORD   = 2'd0;
   localparam logic [1:0] EV_RESET  = 2'd1;
   localparam logic [1:0] EV_REJECT = 2'd2;

   // classified beat handed from front to back
   typedef struct packed {
      logic       is_end;
      logic [3:0] nibble;
      logic       reset_cmd;
      logic       page_cmd;
   } sysl_cmd_type;

   function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
      logic [7:0] v;
      case (pos)
         3'd0: v = SYSEX_START;
         3'd1: v = 8'h00;
         3'd2: v = 8'h21;
         3'd3: v = 8'h02;
         3'd4: v = 8'h00;
         3'd5: v = 8'h09;
         default: v = SYSEX_START;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/sysl_if.sv
// valid/ready channel interfaces for midi beats and loader results
// no dependencies
`default_nettype none

interface sysl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] midi_byte;
   modport source (output valid, output midi_byte, input ready);
   modport sink (input valid, input midi_byte, output ready);
endinterface

interface sysl_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [15:0] flash_address;
   logic [15:0] flash_word;
   logic        last_of_run;
   modport source (output valid, output event_kind, output flash_address,
                   output flash_word, output last_of_run, input ready);
   modport sink (input valid, input event_kind, input flash_address,
                 input flash_word, input last_of_run, output ready);
endinterface

`default_nettype wire

### rtl/sysex_page_loader.sv
// top level of the sysex page loader: front end, beat queue, back end
// depends on sysl_pkg, sysl_if, sysl_front, sysl_queue, sysl_back
//
// Takes one MIDI byte per req beat and turns SysEx page messages into flash
// word writes, reset requests or rejections on the rsp channel. Every byte is
// accepted while the four-beat queue between front and back has room; the back
// end drains one queued data beat per cycle while no page flush is under way,
// so ordinary bytes then sustain one per cycle. A page flush reads the page
// memory one word at a time, passing through BK_READ and then BK_SEND for each
// word and holding in BK_SEND while the rsp side stalls; during a flush the
// front keeps accepting bytes until the queue is full.
`default_nettype none

module sysex_page_loader
   import sysl_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   sysl_req_if.sink   req_chan,
   sysl_rsp_if.source rsp_chan
);

   logic         push;
   sysl_cmd_type push_cmd;
   logic         q_full;
   logic         head_valid;
   sysl_cmd_type head_cmd;
   logic         pop;

   sysl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   sysl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   sysl_back #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

### rtl/sysl_front.sv
// front end: drops bytes above F0 other than F7, matches header and command, classifies data
// depends on sysl_pkg and sysl_if
`default_nettype none

module sysl_front
   import sysl_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sysl_req_if.sink    req_chan,
   input  wire logic   q_full,
   output logic        push,
   output sysl_cmd_type push_cmd
);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_COMMAND = 3'b010,
      PH_DATA    = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] hdr_pos_ff, hdr_pos_in;
   logic [6:0] cmd0_ff, cmd0_in;
   logic       cmd_cnt_ff, cmd_cnt_in;
   logic       reset_cmd_ff, reset_cmd_in;
   logic       page_cmd_ff, page_cmd_in;
   logic       accept;
   logic [7:0] b;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && !q_full;
   assign b = req_chan.midi_byte;

   always_comb begin
      phase_in     = phase_ff;
      hdr_pos_in   = hdr_pos_ff;
      cmd0_in      = cmd0_ff;
      cmd_cnt_in   = cmd_cnt_ff;
      reset_cmd_in = reset_cmd_ff;
      page_cmd_in  = page_cmd_ff;
      push         = 1'b0;
      push_cmd.is_end    = 1'b0;
      push_cmd.nibble    = b[3:0];
      push_cmd.reset_cmd = reset_cmd_ff;
      push_cmd.page_cmd  = page_cmd_ff;
      if (accept && !(b > SYSEX_START && b != SYSEX_END)) begin
         case (phase_ff)
            PH_COMMAND: begin
               if (b < STATUS_BIT) begin
                  if (cmd_cnt_ff) begin
                     cmd_cnt_in   = 1'b0;
                     reset_cmd_in = (cmd0_ff == CMD_RESET) && (b[6:0] == CMD_SUB);
                     page_cmd_in  = (cmd0_ff == CMD_PAGE) && (b[6:0] == CMD_SUB);
                     phase_in     = PH_DATA;
                  end else begin
                     cmd0_in    = b[6:0];
                     cmd_cnt_in = 1'b1;
                  end
               end else begin
                  phase_in   = PH_HEADER;
                  hdr_pos_in = 3'd0;
                  cmd_cnt_in = 1'b0;
               end
            end
            PH_DATA: begin
               if (b < STATUS_BIT) begin
                  push = 1'b1;
               end else if (b == SYSEX_END) begin
                  push            = 1'b1;
                  push_cmd.is_end = 1'b1;
                  phase_in        = PH_HEADER;
                  hdr_pos_in      = 3'd0;
               end
            end
            default: begin
               if (b == hdr_byte(hdr_pos_ff)) begin
                  if (hdr_pos_ff == 3'(HDR_LEN - 1)) begin
                     hdr_pos_in = 3'd0;
                     cmd_cnt_in = 1'b0;
                     phase_in   = PH_COMMAND;
                  end else begin
                     hdr_pos_in = hdr_pos_ff + 3'd1;
                  end
               end else begin
                  hdr_pos_in = 3'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_pos_ff   <= 3'd0;
         cmd0_ff      <= 7'd0;
         cmd_cnt_ff   <= 1'b0;
         reset_cmd_ff <= 1'b0;
         page_cmd_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_pos_ff   <= hdr_pos_in;
         cmd0_ff      <= cmd0_in;
         cmd_cnt_ff   <= cmd_cnt_in;
         reset_cmd_ff <= reset_cmd_in;
         page_cmd_ff  <= page_cmd_in;
      end
   end

endmodule

`default_nettype wire

### rtl/sysl_queue.sv
// short queue of classified beats between front and back
// depends on sysl_pkg
`default_nettype none

module sysl_queue
   import sysl_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire sysl_cmd_type push_cmd,
   output logic        full,
   output logic        head_valid,
   output sysl_cmd_type head_cmd,
   input  wire logic   pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   sysl_cmd_type     slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_pop;

   assign full       = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

### rtl/sysl_back.sv
// back end: packs nibbles into the page memory, checks length and sum, streams page words or reports a reset or reject
// depends on sysl_pkg and sysl_if
`default_nettype none

module sysl_back
   import sysl_pkg::*;
#(
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   head_valid,
   input  wire sysl_cmd_type head_cmd,
   output logic        pop,
   sysl_rsp_if.source  rsp_chan
);

   localparam int WORDS = PAGE_BYTES / 2;
   localparam int AW    = $clog2(WORDS);
   localparam int IW    = $clog2(PAGE_BYTES + 3);
   localparam logic [IW-1:0] IDX_PAGE = IW'(PAGE_BYTES);
   localparam logic [IW-1:0] IDX_FULL = IW'(PAGE_BYTES + 1);
   localparam logic [IW-1:0] IDX_SAT  = IW'(PAGE_BYTES + 2);
   localparam logic [AW-1:0] K_LAST   = AW'(WORDS - 1);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_READ = 3'b010,
      BK_SEND = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [IW-1:0]  widx_ff, widx_in;
   logic           half_ff, half_in;
   logic           seen_ff, seen_in;
   logic [7:0]     sum_ff, sum_in;
   logic [3:0]     hi_ff, hi_in;
   logic [7:0]     lo_ff, lo_in;
   logic [7:0]     check_ff, check_in;
   logic [AW-1:0]  k_ff, k_in;
   logic [15:0]    page_addr_ff, page_addr_in;

   logic           out_valid_ff, out_valid_in;
   logic [1:0]     kind_ff, kind_in;
   logic [15:0]    addr_ff, addr_in;
   logic [15:0]    word_ff, word_in;
   logic           last_ff, last_in;

   logic [15:0]    mem [WORDS];
   logic [15:0]    rd_data_ff;
   logic           mem_we;
   logic [7:0]     byte_v;
   logic           out_free;
   logic           reset_ok;
   logic           page_ok;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign byte_v   = {hi_ff, head_cmd.nibble};
   assign reset_ok = head_cmd.reset_cmd && !seen_ff;
   assign page_ok  = head_cmd.page_cmd && (widx_ff == IDX_FULL) && (check_ff == sum_ff);

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.event_kind    = kind_ff;
   assign rsp_chan.flash_address = addr_ff;
   assign rsp_chan.flash_word    = word_ff;
   assign rsp_chan.last_of_run   = last_ff;

   always_comb begin
      state_in     = state_ff;
      widx_in      = widx_ff;
      half_in      = half_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      check_in     = check_ff;
      k_in         = k_ff;
      page_addr_in = page_addr_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;
      mem_we       = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid && !head_cmd.is_end) begin
               pop     = 1'b1;
               seen_in = 1'b1;
               if (!half_ff) begin
                  hi_in   = head_cmd.nibble;
                  half_in = 1'b1;
               end else begin
                  half_in = 1'b0;
                  if (widx_ff < IDX_PAGE) begin
                     sum_in = sum_ff + byte_v;
                     if (!widx_ff[0]) begin
                        lo_in = byte_v;
                     end else begin
                        mem_we = 1'b1;
                     end
                  end
                  if (widx_ff == IDX_PAGE) begin
                     check_in = byte_v;
                  end
                  if (widx_ff < IDX_SAT) begin
                     widx_in = widx_ff + 1'b1;
                  end
               end
            end else if (head_valid && out_free) begin
               pop     = 1'b1;
               widx_in = '0;
               sum_in  = 8'd0;
               half_in = 1'b0;
               seen_in = 1'b0;
               if (reset_ok || !page_ok) begin
                  out_valid_in = 1'b1;
                  kind_in      = reset_ok ? EV_RESET : EV_REJECT;
                  addr_in      = 16'd0;
                  word_in      = 16'd0;
                  last_in      = 1'b1;
               end else begin
                  k_in     = '0;
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            state_in = BK_SEND;
         end
         BK_SEND: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               kind_in      = EV_WORD;
               addr_in      = page_addr_ff + 16'({k_ff, 1'b0});
               word_in      = rd_data_ff;
               last_in      = (k_ff == K_LAST);
               if (k_ff == K_LAST) begin
                  page_addr_in = page_addr_ff + 16'(PAGE_BYTES);
                  state_in     = BK_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = BK_READ;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         widx_ff      <= '0;
         half_ff      <= 1'b0;
         seen_ff      <= 1'b0;
         sum_ff       <= 8'd0;
         page_addr_ff <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         widx_ff      <= widx_in;
         half_ff      <= half_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         page_addr_ff <= page_addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      check_ff <= check_in;
      k_ff     <= k_in;
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      word_ff  <= word_in;
      last_ff  <= last_in;
   end

   // page memory, one word per pair of bytes, little endian
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[widx_ff[AW:1]] <= {byte_v, lo_ff};
      end
      rd_data_ff <= mem[k_ff];
   end

endmodule

`default_nettype wire

### dv/tb_sysex_page_loader.sv
// self-checking testbench for sysex_page_loader: midi beats in, flash words out
// depends on sysl_pkg, sysl_if and the sysex_page_loader rtl
`timescale 1ns / 1ps

module tb_sysex_page_loader
   import sysl_pkg::*;
();

   localparam int PAGE_LEN    = PAGE_BYTES_DEF;
   localparam int SHORT_BODY  = 4;
   localparam int BUSY_MSGS   = 1;
   localparam int CALM_MSGS   = 2;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN       = 400;
   localparam logic [8*HDR_LEN-1:0] HEADER_SEQ =
      {SYSEX_START, 8'h00, 8'h21, 8'h02, 8'h00, 8'h09};

   typedef enum logic [1:0] {P_HEADER, P_COMMAND, P_DATA} parse_phase_type;

   typedef enum int {
      M_PAGE_OK, M_PAGE_SHORT, M_RESET, M_RESET_DATA, M_OTHER_CMD, M_BROKEN_HDR,
      M_CMD_ABORT, M_NOISE
   } msg_kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [15:0] word;
      logic        last;
   } loader_result_type;

   typedef struct packed {
      logic [7:0] beat;
      logic       pinned;
      logic [1:0] kind;
   } script_row_type;

   logic clock;
   logic reset;

   sysl_req_if req_chan ();
   sysl_rsp_if rsp_chan ();

   sysex_page_loader #(.PAGE_BYTES(PAGE_LEN)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // loader state as the parser sees it
   parse_phase_type parse_ph = P_HEADER;
   int         hdr_pos     = 0;
   logic [6:0] cmd_first   = '0;
   logic [6:0] cmd_second  = '0;
   bit         cmd_half    = 0;
   bit         nib_pending = 0;
   bit         saw_data    = 0;
   int         fill_idx    = 0;
   logic [7:0] page_sum    = '0;
   logic [7:0] page_mem [0:PAGE_LEN];
   logic [15:0] page_base  = '0;

   loader_result_type fresh[$];
   loader_result_type pending_results[$];
   logic [7:0]        outgoing[$];

   int  mismatches    = 0;
   int  checked       = 0;
   int  beats_sent    = 0;
   int  pages_written = 0;
   int  resets_seen   = 0;
   int  rejects_seen  = 0;
   int  holds_asked   = 0;
   int  holds_done    = 0;
   bit  calm          = 0;
   bit  noise_on      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic void predict_beat(input logic [7:0] b);
      if (b > SYSEX_START && b != SYSEX_END) return;
      case (parse_ph)
         P_COMMAND: begin
            if (b < STATUS_BIT) begin
               if (cmd_half) begin
                  cmd_second  = b[6:0];
                  cmd_half    = 0;
                  fill_idx    = 0;
                  page_sum    = '0;
                  nib_pending = 0;
                  saw_data    = 0;
                  parse_ph    = P_DATA;
               end else begin
                  cmd_first = b[6:0];
                  cmd_half  = 1;
               end
            end else begin
               parse_ph = P_HEADER;
               hdr_pos  = 0;
               cmd_half = 0;
            end
         end
         P_DATA: begin
            if (b < STATUS_BIT) begin
               if (nib_pending) begin
                  if (fill_idx <= PAGE_LEN) begin
                     page_mem[fill_idx] = page_mem[fill_idx] | {4'h0, b[3:0]};
                     if (fill_idx < PAGE_LEN) page_sum += page_mem[fill_idx];
                  end
                  if (fill_idx < PAGE_LEN + 2) fill_idx++;
                  nib_pending = 0;
               end else begin
                  if (fill_idx <= PAGE_LEN) page_mem[fill_idx] = {b[3:0], 4'h0};
                  nib_pending = 1;
               end
               saw_data = 1;
            end else if (b == SYSEX_END) begin
               if (cmd_first == CMD_RESET && cmd_second == CMD_SUB && !saw_data) begin
                  fresh.push_back(loader_result_type'{EV_RESET, 16'h0, 16'h0, 1'b1});
                  resets_seen++;
               end else if (fill_idx == PAGE_LEN + 1 && cmd_first == CMD_PAGE &&
                            cmd_second == CMD_SUB && page_mem[PAGE_LEN] == page_sum) begin
                  for (int i = 0; i < PAGE_LEN; i += 2)
                     fresh.push_back(loader_result_type'{EV_WORD, page_base + 16'(i),
                        {page_mem[i + 1], page_mem[i]}, (i + 2 >= PAGE_LEN)});
                  page_base += 16'(PAGE_LEN);
                  pages_written++;
               end else begin
                  fresh.push_back(loader_result_type'{EV_REJECT, 16'h0, 16'h0, 1'b1});
                  rejects_seen++;
               end
               parse_ph    = P_HEADER;
               hdr_pos     = 0;
               nib_pending = 0;
               saw_data    = 0;
            end
         end
         default: begin
            if (hdr_pos < HDR_LEN && b == HEADER_SEQ[8*(HDR_LEN-1-hdr_pos) +: 8]) begin
               hdr_pos++;
               if (hdr_pos == HDR_LEN) begin
                  hdr_pos  = 0;
                  cmd_half = 0;
                  parse_ph = P_COMMAND;
               end
            end else begin
               hdr_pos = 0;
            end
         end
      endcase
   endfunction

   function automatic void put(input logic [7:0] b);
      if (noise_on && $urandom_range(0, 29) == 0)
         outgoing.push_back(($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'hF1, 8'hF6))
                                                         : 8'($urandom_range(8'hF8, 8'hFF)));
      outgoing.push_back(b);
   endfunction

   // status bytes below sysex end are dropped silently inside the data part
   function automatic void put_data(input logic [7:0] b);
      if (noise_on && $urandom_range(0, 24) == 0)
         outgoing.push_back(8'($urandom_range(8'h80, 8'hF0)));
      put(b);
   endfunction

   function automatic void put_header();
      for (int i = 0; i < HDR_LEN; i++) put(HEADER_SEQ[8*(HDR_LEN-1-i) +: 8]);
   endfunction

   function automatic void put_page_body(input int count, input bit extra_nibble);
      logic [7:0] v;
      logic [7:0] sum;
      int         pattern;
      sum     = '0;
      pattern = $urandom_range(0, 7);
      for (int i = 0; i < count; i++) begin
         v = (pattern == 0) ? 8'hFF : (pattern == 1) ? 8'h00 : 8'($urandom);
         if (i < PAGE_LEN) sum += v;
         else if (i == PAGE_LEN) v = sum;
         put_data({1'b0, 3'($urandom), v[7:4]});
         put_data({1'b0, 3'($urandom), v[3:0]});
      end
      if (extra_nibble) put_data({1'b0, 7'($urandom)});
   endfunction

   function automatic void compose_message(input msg_kind_type k);
      int cut;
      case (k)
         M_RESET, M_RESET_DATA: begin
            put_header();
            put({1'b0, CMD_RESET});
            put({1'b0, CMD_SUB});
            if (k == M_RESET_DATA) put_page_body($urandom_range(0, 2), 1'b1);
            put(SYSEX_END);
         end
         M_OTHER_CMD: begin
            put_header();
            case ($urandom_range(0, 2))
               0: begin put({1'b0, CMD_PAGE}); put(8'($urandom_range(1, 127))); end
               1: begin put({1'b0, CMD_RESET}); put(8'($urandom_range(1, 127))); end
               default: begin put(8'($urandom_range(0, 127))); put(8'($urandom_range(0, 127))); end
            endcase
            put_page_body($urandom_range(0, SHORT_BODY), 1'b0);
            put(SYSEX_END);
         end
         M_BROKEN_HDR: begin
            cut = $urandom_range(0, HDR_LEN - 1);
            for (int i = 0; i < cut; i++) put(HEADER_SEQ[8*(HDR_LEN-1-i) +: 8]);
            put(8'($urandom_range(0, 255)));
            put({1'b0, CMD_RESET});
            put({1'b0, CMD_SUB});
            put(SYSEX_END);
         end
         M_CMD_ABORT: begin
            put_header();
            if ($urandom_range(0, 1) != 0) put(8'($urandom_range(0, 127)));
            put(($urandom_range(0, 1) != 0) ? SYSEX_END : 8'($urandom_range(8'h80, 8'hF0)));
         end
         M_NOISE: begin
            repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
         end
         default: begin
            put_header();
            put({1'b0, CMD_PAGE});
            put({1'b0, CMD_SUB});
            if (k == M_PAGE_SHORT) put_page_body($urandom_range(0, SHORT_BODY), 1'b0);
            else put_page_body(PAGE_LEN + 1, 1'($urandom_range(0, 1)));
            put(SYSEX_END);
         end
      endcase
   endfunction

   function automatic msg_kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) return M_PAGE_SHORT;
      if (r < 40) return M_RESET;
      if (r < 52) return M_RESET_DATA;
      if (r < 66) return M_OTHER_CMD;
      if (r < 80) return M_BROKEN_HDR;
      if (r < 92) return M_CMD_ABORT;
      return M_NOISE;
   endfunction

   function automatic void check_result();
      loader_result_type want;
      if (pending_results.size() == 0) begin
         $error("result with nothing expected: kind %0d address %h word %h",
                rsp_chan.event_kind, rsp_chan.flash_address, rsp_chan.flash_word);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      checked++;
      if (rsp_chan.event_kind !== want.kind) begin
         $error("event_kind: expected %0d, actual %0d", want.kind, rsp_chan.event_kind);
         mismatches++;
      end
      if (rsp_chan.flash_address !== want.addr) begin
         $error("flash_address: expected %h, actual %h", want.addr, rsp_chan.flash_address);
         mismatches++;
      end
      if (rsp_chan.flash_word !== want.word) begin
         $error("flash_word: expected %h, actual %h", want.word, rsp_chan.flash_word);
         mismatches++;
      end
      if (rsp_chan.last_of_run !== want.last) begin
         $error("last_of_run: expected %0d, actual %0d", want.last, rsp_chan.last_of_run);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) check_result();
   end

   // beat is accepted on the first edge with ready high; valid stays up for the next one
   task automatic offer_beat(input logic [7:0] b);
      req_chan.valid     <= 1'b1;
      req_chan.midi_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      beats_sent++;
      predict_beat(b);
   endtask

   task automatic send_outgoing();
      logic [7:0] b;
      while (outgoing.size() != 0) begin
         b = outgoing.pop_front();
         if (!calm && $urandom_range(0, 9) == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         offer_beat(b);
         while (fresh.size() != 0) pending_results.push_back(fresh.pop_front());
      end
   endtask

   initial begin
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < holds_asked && rsp_chan.valid) begin
            holds_done++;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      script_row_type script [24];
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.midi_byte <= 8'h00;
      // header restart on a stray start byte, reset request, then a reset
      // command carrying data with a status and a realtime byte mixed in
      script = '{
         '{8'hF0, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'hF0, 1'b0, EV_WORD},
         '{8'hF0, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'h21, 1'b0, EV_WORD},
         '{8'h02, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'h09, 1'b0, EV_WORD},
         '{8'h7F, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'hF7, 1'b1, EV_RESET},
         '{8'hF0, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'h21, 1'b0, EV_WORD},
         '{8'h02, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'h09, 1'b0, EV_WORD},
         '{8'h7F, 1'b0, EV_WORD}, '{8'h00, 1'b0, EV_WORD}, '{8'h7F, 1'b0, EV_WORD},
         '{8'h85, 1'b0, EV_WORD}, '{8'hFF, 1'b0, EV_WORD}, '{8'hF7, 1'b1, EV_REJECT}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[r]) begin
         offer_beat(script[r].beat);
         if (script[r].pinned) begin
            fresh.delete();
            pending_results.push_back(loader_result_type'{script[r].kind, 16'h0, 16'h0, 1'b1});
         end
         while (fresh.size() != 0) pending_results.push_back(fresh.pop_front());
      end

      // sender waits until the directed results are all out
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);

      // receiver sits on the page flush while the next message keeps coming
      noise_on = 1;
      holds_asked++;
      compose_message(M_PAGE_OK);
      compose_message(M_RESET);
      send_outgoing();

      repeat (BUSY_MSGS) begin
         compose_message(pick_kind());
         send_outgoing();
      end

      calm = 1;
      repeat (CALM_MSGS) begin
         compose_message(pick_kind());
         send_outgoing();
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("run: %0d midi beats with header restarts, aborts and noise, %0d pages, %0d resets, %0d rejects",
               beats_sent, pages_written, resets_seen, rejects_seen);
      $display("run: %0d results checked across a long receiver stall, %0d mismatches",
               checked, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
